// ===== hw/rtl/hkle_pkg.sv =====
package hkle_pkg;

    localparam int NUM_SLOTS = 6;
    localparam int SLOT_W    = 3;
    localparam int QDEPTH    = 2;

    localparam logic [7:0] CODE_BKSP  = 8'h2A;
    localparam logic [7:0] CODE_ENTER = 8'h28;
    localparam logic [7:0] CODE_ESC   = 8'h29;

    localparam int LSHIFT_BIT = 1;
    localparam int RSHIFT_BIT = 5;

    // slot classes handed from front to back
    localparam logic [2:0] CLS_NONE  = 3'd0;
    localparam logic [2:0] CLS_CHAR  = 3'd1;
    localparam logic [2:0] CLS_BKSP  = 3'd2;
    localparam logic [2:0] CLS_ENTER = 3'd3;
    localparam logic [2:0] CLS_ESC   = 3'd4;

    // event kinds on the output
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_BKSP = 2'd1;
    localparam logic [1:0] KIND_RET  = 2'd2;
    localparam logic [1:0] KIND_ESC  = 2'd3;

    typedef struct packed {
        logic [2:0] cls;
        logic [7:0] ch;
    } t_slot;

    typedef t_slot [NUM_SLOTS-1:0] t_report;

    // uk layout, plain or shifted; zero means unmapped
    function automatic logic [7:0] map_key(input logic [6:0] code, input logic shift);
        logic [7:0] ch;
        ch = 8'h00;
        if (code inside {[7'h04:7'h1D]}) begin
            ch = (shift ? 8'h41 : 8'h61) + {1'b0, code} - 8'h04;
        end else begin
            case (code)
                7'h1E: ch = shift ? 8'h21 : 8'h31;
                7'h1F: ch = shift ? 8'h22 : 8'h32;
                7'h20: ch = shift ? 8'hA3 : 8'h33;
                7'h21: ch = shift ? 8'h24 : 8'h34;
                7'h22: ch = shift ? 8'h25 : 8'h35;
                7'h23: ch = shift ? 8'h5E : 8'h36;
                7'h24: ch = shift ? 8'h26 : 8'h37;
                7'h25: ch = shift ? 8'h2A : 8'h38;
                7'h26: ch = shift ? 8'h28 : 8'h39;
                7'h27: ch = shift ? 8'h29 : 8'h30;
                7'h2C: ch = shift ? 8'h00 : 8'h20;
                7'h2D: ch = shift ? 8'h5F : 8'h2D;
                7'h2E: ch = shift ? 8'h2B : 8'h3D;
                7'h2F: ch = shift ? 8'h7B : 8'h5B;
                7'h30: ch = shift ? 8'h7D : 8'h5D;
                7'h31: ch = shift ? 8'h7E : 8'h23;
                7'h32: ch = shift ? 8'h7C : 8'h5C;
                7'h33: ch = shift ? 8'h3A : 8'h3B;
                7'h34: ch = shift ? 8'h40 : 8'h27;
                7'h35: ch = shift ? 8'hAC : 8'h60;
                7'h36: ch = shift ? 8'h3C : 8'h2C;
                7'h37: ch = shift ? 8'h3E : 8'h2E;
                7'h38: ch = shift ? 8'h3F : 8'h2F;
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

endpackage

// ===== hw/rtl/hkle_front.sv =====
module hkle_front
    import hkle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [55:0] i_data,
    input  logic        i_full,
    output logic        o_ready,
    output logic        o_push,
    output t_report     o_report
);

    logic [NUM_SLOTS-1:0][7:0] r_prev;
    logic [NUM_SLOTS-1:0][7:0] w_codes;
    logic                      w_shift;
    logic                      w_accept;

    assign w_shift  = i_data[LSHIFT_BIT] | i_data[RSHIFT_BIT];
    assign o_ready  = ~i_full;
    assign w_accept = i_valid & ~i_full;
    assign o_push   = w_accept;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            w_codes[i] = i_data[8*(i+1) +: 8];
        end
    end

    always_comb begin
        logic       held;
        logic [7:0] ch;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            held = 1'b0;
            for (int j = 0; j < NUM_SLOTS; j++) begin
                if (r_prev[j] == w_codes[i]) held = 1'b1;
            end
            ch = map_key(w_codes[i][6:0], w_shift);
            o_report[i].ch = 8'h00;
            if (w_codes[i] == 8'h00 || held) begin
                o_report[i].cls = CLS_NONE;
            end else if (w_codes[i] == CODE_BKSP) begin
                o_report[i].cls = CLS_BKSP;
            end else if (w_codes[i] == CODE_ENTER) begin
                o_report[i].cls = CLS_ENTER;
            end else if (w_codes[i] == CODE_ESC) begin
                o_report[i].cls = CLS_ESC;
            end else if (w_codes[i][7] || ch == 8'h00) begin
                o_report[i].cls = CLS_NONE;
            end else begin
                o_report[i].cls = CLS_CHAR;
                o_report[i].ch  = ch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (w_accept) begin
            r_prev <= w_codes;
        end
    end

endmodule

// ===== hw/rtl/hkle_queue.sv =====
module hkle_queue
    import hkle_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_report i_wdata,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_valid,
    output t_report o_rdata
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_report             r_mem [QDEPTH];
    logic [PTR_W-1:0]    r_wptr;
    logic [PTR_W-1:0]    r_rptr;
    logic [CNT_W-1:0]    r_cnt;
    logic [PTR_W-1:0]    n_wptr;
    logic [PTR_W-1:0]    n_rptr;
    logic                w_do_pop;

    assign o_full   = (r_cnt == CNT_W'(QDEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_rdata  = r_mem[r_rptr];
    assign w_do_pop = i_pop & o_valid;
    assign n_wptr   = (r_wptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
    assign n_rptr   = (r_rptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= n_wptr;
            if (w_do_pop) r_rptr <= n_rptr;
            if (i_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && w_do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/hkle_back.sv =====
module hkle_back
    import hkle_pkg::*;
#(
    parameter int LINE_CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_report     i_report,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [23:0] o_tdata,
    output logic        o_tlast
);

    localparam int CNT_W = $clog2(LINE_CAPACITY);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_CAPACITY - 1);

    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    logic [1:0]        r_kind;
    logic [7:0]        r_char;
    logic [5:0]        r_pos;
    logic [5:0]        r_len;
    logic              r_last;

    t_slot             w_cur;
    logic              w_emit;
    logic [1:0]        w_kind;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  w_pos;
    logic [CNT_W+5:0]  w_pos_ext;
    logic [CNT_W+5:0]  w_len_ext;
    logic              w_later_fix;
    logic              w_later_char;
    logic              w_later_bksp;
    logic              w_last;
    logic              w_go;

    assign w_cur = i_report[r_slot];

    always_comb begin
        w_emit  = 1'b0;
        w_kind  = KIND_CHAR;
        n_count = r_count;
        w_pos   = '0;
        case (w_cur.cls)
            CLS_CHAR: begin
                w_emit  = (r_count < CNT_MAX);
                n_count = r_count + 1'b1;
                w_pos   = r_count;
            end
            CLS_BKSP: begin
                w_emit  = (r_count != '0);
                w_kind  = KIND_BKSP;
                n_count = r_count - 1'b1;
                w_pos   = n_count;
            end
            CLS_ENTER: begin
                w_emit = 1'b1;
                w_kind = KIND_RET;
            end
            CLS_ESC: begin
                w_emit = 1'b1;
                w_kind = KIND_ESC;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // what the remaining slots of this report hold
    always_comb begin
        w_later_fix  = 1'b0;
        w_later_char = 1'b0;
        w_later_bksp = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (SLOT_W'(i) > r_slot) begin
                if (i_report[i].cls == CLS_ENTER || i_report[i].cls == CLS_ESC)
                    w_later_fix = 1'b1;
                if (i_report[i].cls == CLS_CHAR) w_later_char = 1'b1;
                if (i_report[i].cls == CLS_BKSP) w_later_bksp = 1'b1;
            end
        end
    end

    // a later char and a later backspace can never both be blocked
    assign w_last = ~(w_later_fix
                    | (w_later_char & w_later_bksp)
                    | (w_later_char & (n_count < CNT_MAX))
                    | (w_later_bksp & (n_count != '0)));

    assign w_go      = i_valid & (~w_emit | ~r_out_valid | i_tready);
    assign o_pop     = w_go & (r_slot == SLOT_W'(NUM_SLOTS - 1));
    assign w_pos_ext = {6'b0, w_pos};
    assign w_len_ext = {6'b0, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go) begin
                r_slot <= o_pop ? '0 : r_slot + 1'b1;
                if (w_emit) r_count <= n_count;
            end
            if (w_go && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_emit) begin
            r_kind <= w_kind;
            r_char <= (w_kind == KIND_CHAR) ? w_cur.ch : 8'h00;
            r_pos  <= w_pos_ext[5:0];
            r_len  <= w_len_ext[5:0];
            r_last <= w_last;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {2'b00, r_len, r_pos, r_char, r_kind};
    assign o_tlast  = r_last;

endmodule

// ===== hw/rtl/hid_keyboard_line_editor.sv =====
// boot keyboard report to line edit events
//
// input stream: one transfer per 8-byte boot report (reserved byte dropped).
// output stream: one transfer per edit event, tlast on the final event of a
// report; a report that causes no event gives no transfer at all.
//
// the front classifies the six slots in the accept cycle (release/hold
// filter against the previous report, shift, uk key map) and writes the
// result into a two-report queue. the back walks the six slots of the queue
// head at one slot per cycle unless a slot that emits finds the output
// register full and not taken, tracking the line length, and loads the
// output register. events pass the queue, then the output register; the
// queue takes reports while the back walks all six slots of its head.
//
// reset clears the remembered keys, the line length, the queue and the
// output register. when the receiver stalls, the held event stays put, the
// back stops at the slot that wants to emit, the queue fills and s_axis
// tready drops after two waiting reports.
module hid_keyboard_line_editor
    import hkle_pkg::*;
#(
    parameter int LINE_CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // modifier_bits, key_code_0 .. key_code_5
    input  logic [55:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // event_kind, event_char, edit_position, line_length, 2 bits zero
    output logic [23:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    logic    w_push;
    logic    w_full;
    logic    w_qvalid;
    logic    w_pop;
    t_report w_wreport;
    t_report w_rreport;

    hkle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_data   (i_s_axis_tdata),
        .i_full   (w_full),
        .o_ready  (o_s_axis_tready),
        .o_push   (w_push),
        .o_report (w_wreport)
    );

    hkle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_wreport),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_rdata (w_rreport)
    );

    hkle_back #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_qvalid),
        .i_report (w_rreport),
        .o_pop    (w_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule

// ===== hw/rtl/hkle_checker.sv =====
module hkle_checker
    import hkle_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // reset empties the queue and the output register
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("outputs not idle after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("event changed while stalled");

    // an appended char grows the line past its position
    a_char_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] == KIND_CHAR |->
            o_m_axis_tdata[21:16] == 6'(o_m_axis_tdata[15:10] + 6'd1))
        else $error("char event length mismatch");

    a_bksp_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] == KIND_BKSP |->
            o_m_axis_tdata[21:16] == o_m_axis_tdata[15:10]
            && o_m_axis_tdata[9:2] == 8'h00)
        else $error("backspace event mismatch");

endmodule

bind hid_keyboard_line_editor hkle_checker u_hkle_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import hkle_pkg::*;

    localparam int LINE_CAP   = 64;
    localparam int RANDOM_N   = 320;
    localparam int CALM_FROM  = 23 + RANDOM_N - 40;
    localparam int LONG_HOLD  = 120;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [5:0] pos;
        logic [5:0] len;
        logic       last;
    } t_edit_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [55:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    logic [55:0]  reports_to_send[$];
    t_edit_event  expected_events[$];
    logic [7:0]   typed_keys[NUM_SLOTS];
    logic [7:0]   held_keys[NUM_SLOTS];
    int           line_len = 0;
    int           reports_taken = 0;
    int           events_seen = 0;
    int           error_count = 0;
    int           send_gap = 0;
    int           recv_stall = 0;
    logic         long_hold_done = 1'b0;

    hid_keyboard_line_editor #(
        .LINE_CAPACITY(LINE_CAP)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // uk layout lookup, zero when the code has no character
    function automatic logic [7:0] uk_char(input logic [7:0] code, input logic shift);
        string plain_row;
        string shift_row;
        string plain_punct;
        string shift_punct;
        logic [7:0] c;
        plain_row   = "abcdefghijklmnopqrstuvwxyz1234567890";
        shift_row   = "ABCDEFGHIJKLMNOPQRSTUVWXYZ!\"#$%^&*()";
        plain_punct = " -=[]#\\;'`,./";
        shift_punct = " _+{}~|:@`<>?";
        c = 8'h00;
        if (code >= 8'h04 && code <= 8'h27) begin
            c = shift ? shift_row[code - 8'h04] : plain_row[code - 8'h04];
            // shifted 3 is the pound sign in latin-1
            if (shift && code == 8'h20) begin
                c = 8'hA3;
            end
        end else if (code >= 8'h2C && code <= 8'h38) begin
            c = shift ? shift_punct[code - 8'h2C] : plain_punct[code - 8'h2C];
            if (shift && code == 8'h2C) begin
                c = 8'h00;
            end
            // shifted grave is the not sign
            if (shift && code == 8'h35) begin
                c = 8'hAC;
            end
        end
        return c;
    endfunction

    // line editor behavior for one report, appends the events it causes
    task automatic apply_report(input logic [55:0] rpt);
        t_edit_event report_events[$];
        t_edit_event ev;
        logic [7:0]  codes[NUM_SLOTS];
        logic [7:0]  code;
        logic [7:0]  c;
        logic        shift;
        logic        held;
        shift = rpt[LSHIFT_BIT] | rpt[RSHIFT_BIT];
        for (int s = 0; s < NUM_SLOTS; s++) begin
            codes[s] = rpt[8*(s+1) +: 8];
        end
        for (int s = 0; s < NUM_SLOTS; s++) begin
            code = codes[s];
            held = 1'b0;
            for (int j = 0; j < NUM_SLOTS; j++) begin
                if (held_keys[j] == code) begin
                    held = 1'b1;
                end
            end
            if (code == 8'h00 || held) begin
                continue;
            end
            ev.ch   = 8'h00;
            ev.pos  = '0;
            ev.last = 1'b0;
            if (code == CODE_BKSP) begin
                if (line_len == 0) begin
                    continue;
                end
                line_len--;
                ev.kind = KIND_BKSP;
                ev.pos  = 6'(line_len);
            end else if (code == CODE_ENTER) begin
                ev.kind = KIND_RET;
            end else if (code == CODE_ESC) begin
                ev.kind = KIND_ESC;
            end else begin
                c = (code > 8'd127) ? 8'h00 : uk_char(code, shift);
                if (c == 8'h00 || line_len >= LINE_CAP - 1) begin
                    continue;
                end
                ev.kind = KIND_CHAR;
                ev.ch   = c;
                ev.pos  = 6'(line_len);
                line_len++;
            end
            ev.len = 6'(line_len);
            report_events.push_back(ev);
        end
        if (report_events.size() > 0) begin
            report_events[report_events.size() - 1].last = 1'b1;
        end
        foreach (report_events[k]) begin
            expected_events.push_back(report_events[k]);
        end
        held_keys = codes;
    endtask

    task automatic push_report(input logic [7:0] m, input logic [7:0] c0, input logic [7:0] c1,
                               input logic [7:0] c2, input logic [7:0] c3,
                               input logic [7:0] c4, input logic [7:0] c5);
        reports_to_send.push_back({c5, c4, c3, c2, c1, c0, m});
        typed_keys[0] = c0;
        typed_keys[1] = c1;
        typed_keys[2] = c2;
        typed_keys[3] = c3;
        typed_keys[4] = c4;
        typed_keys[5] = c5;
    endtask

    // typing with random content; bksp_pct steers the line toward full or empty
    task automatic queue_random_report(input int bksp_pct, input int release_pct);
        logic [7:0] codes[NUM_SLOTS];
        logic [7:0] m;
        int         roll;
        m = 8'($urandom_range(0, 255));
        for (int s = 0; s < NUM_SLOTS; s++) begin
            codes[s] = 8'h00;
        end
        if (int'($urandom_range(0, 99)) >= release_pct) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                roll = $urandom_range(0, 99);
                if (roll < bksp_pct) begin
                    codes[s] = CODE_BKSP;
                end else if (roll < bksp_pct + 6) begin
                    codes[s] = typed_keys[$urandom_range(0, NUM_SLOTS - 1)];
                end else if (roll < bksp_pct + 10) begin
                    codes[s] = roll[0] ? CODE_ENTER : CODE_ESC;
                end else if (roll < bksp_pct + 18) begin
                    codes[s] = 8'h00;
                end else if (roll < bksp_pct + 24) begin
                    codes[s] = 8'($urandom_range(0, 255));
                end else begin
                    codes[s] = 8'($urandom_range(8'h04, 8'h38));
                end
            end
        end
        push_report(m, codes[0], codes[1], codes[2], codes[3], codes[4], codes[5]);
    endtask

    task automatic wait_for_drain();
        int guard;
        guard = 0;
        while ((reports_to_send.size() != 0 || s_tvalid || expected_events.size() != 0)
               && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // report driver
    always @(posedge i_clk) begin
        logic fire;
        fire = s_tvalid && o_s_axis_tready;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (fire) begin
                apply_report(s_tdata);
                reports_taken <= reports_taken + 1;
            end
            if (!s_tvalid || fire) begin
                if (send_gap == 0 && reports_taken < CALM_FROM && reports_to_send.size() != 0
                    && $urandom_range(0, 4) == 0) begin
                    send_gap = $urandom_range(1, 8);
                end
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (reports_to_send.size() != 0) begin
                    s_tdata  <= reports_to_send.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // event monitor and checker
    always @(posedge i_clk) begin
        t_edit_event want;
        t_edit_event got;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                got.kind = o_m_axis_tdata[1:0];
                got.ch   = o_m_axis_tdata[9:2];
                got.pos  = o_m_axis_tdata[15:10];
                got.len  = o_m_axis_tdata[21:16];
                got.last = o_m_axis_tlast;
                events_seen++;
                if (expected_events.size() == 0) begin
                    $display(
                        "%0t: unexpected event kind=%0d char=%h pos=%0d len=%0d last=%0b",
                        $time, got.kind, got.ch, got.pos, got.len, got.last);
                    error_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (got.kind != want.kind || got.ch != want.ch || got.pos != want.pos
                        || got.len != want.len || got.last != want.last) begin
                        $display(
                            "%0t: expected kind=%0d char=%h pos=%0d len=%0d last=%0b",
                            $time, want.kind, want.ch, want.pos, want.len, want.last);
                        $display(
                            "%0t: actual   kind=%0d char=%h pos=%0d len=%0d last=%0b",
                            $time, got.kind, got.ch, got.pos, got.len, got.last);
                        error_count++;
                    end
                end
            end
            // one long hold-off so the input side backs up
            if (!long_hold_done && events_seen >= 60) begin
                long_hold_done = 1'b1;
                recv_stall = LONG_HOLD;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else if (reports_taken < CALM_FROM && $urandom_range(0, 5) == 0) begin
                recv_stall = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #400000;
        $display("testbench: errors");
        $finish;
    end

    initial begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            typed_keys[s] = 8'h00;
            held_keys[s]  = 8'h00;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // plain letters, digits, space, dash
        push_report(8'h00, 8'h04, 8'h1D, 8'h1E, 8'h27, 8'h2C, 8'h2D);
        push_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // left shift: pound, not, shifted space has no character
        push_report(8'h02, 8'h20, 8'h35, 8'h2C, 8'h31, 8'h38, 8'h04);
        push_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // right shift with unmapped codes and codes above 127
        push_report(8'h20, 8'h2B, 8'h80, 8'hFF, 8'h7F, 8'h39, 8'h2A);
        // return, escape, repeated codes within one report
        push_report(8'h00, 8'h28, 8'h29, 8'h05, 8'h05, 8'h2A, 8'h2A);
        // same report again, every key still held
        push_report(8'h00, 8'h28, 8'h29, 8'h05, 8'h05, 8'h2A, 8'h2A);
        // other modifier bits do not shift
        push_report(8'hDD, 8'h2E, 8'h2F, 8'h30, 8'h32, 8'h33, 8'h34);
        push_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        push_report(8'hFF, 8'h36, 8'h37, 8'h38, 8'h35, 8'h33, 8'h1D);
        // erase the whole line, the last round hits an empty line
        for (int r = 0; r < 5; r++) begin
            push_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            push_report(8'h00, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A);
        end
        push_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h28);
        push_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        wait_for_drain();

        for (int n = 0; n < RANDOM_N; n++) begin
            // sender holds back until every event so far has been seen
            if (n == RANDOM_N / 2) begin
                wait_for_drain();
            end
            if ((n / 40) % 2 == 0) begin
                queue_random_report(3, 10);
            end else begin
                queue_random_report(70, 30);
            end
        end

        wait_for_drain();
        repeat (30) @(posedge i_clk);
        if (expected_events.size() != 0) begin
            $display("%0t: %0d expected events never arrived", $time, expected_events.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
